// File: rtl/core/mips_subset_register_alu_executor_unit_macros.svh
// Assertion macros used by the executor back end.
`ifndef MIPS_SUBSET_REGISTER_ALU_EXECUTOR_UNIT_MACROS_SVH
`define MIPS_SUBSET_REGISTER_ALU_EXECUTOR_UNIT_MACROS_SVH

// Same-cycle implication.
`define MSRAE_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication.
`define MSRAE_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: rtl/core/msrae_pkg.sv
// Types and constants shared by the executor modules.
`timescale 1ns / 1ps

package msrae_pkg;

   localparam int REG_W       = 5;
   localparam int DATA_W      = 32;
   localparam int PC_W        = 16;
   localparam int QUEUE_DEPTH = 4;

   localparam logic [PC_W-1:0] SLICE_LIMIT_RESET    = 16'd100;
   localparam logic [PC_W-1:0] PROGRAM_LENGTH_RESET = 16'd0;

   typedef enum logic [3:0] {
      OP_LI     = 4'd0,
      OP_ADD    = 4'd1,
      OP_SUB    = 4'd2,
      OP_ADDI   = 4'd3,
      OP_MUL    = 4'd4,
      OP_AND    = 4'd5,
      OP_OR_REG = 4'd6,
      OP_OR_IMM = 4'd7,
      OP_XOR    = 4'd8,
      OP_SLL    = 4'd9,
      OP_SRL    = 4'd10,
      OP_DUMP   = 4'd11,
      OP_NOP    = 4'd12,
      OP_STOP   = 4'd13
   } op_type;

   typedef enum logic [1:0] {
      KIND_EXEC    = 2'd0,
      KIND_DUMP    = 2'd1,
      KIND_REFUSED = 2'd2
   } kind_type;

   typedef enum logic {
      CSR_SLICE_LIMIT    = 1'b0,
      CSR_PROGRAM_LENGTH = 1'b1
   } csr_idx_type;

   typedef struct packed {
      op_type              op;
      logic                writes;
      logic [REG_W-1:0]    dest;
      logic [REG_W-1:0]    src_a;
      logic [REG_W-1:0]    src_b;
      logic [DATA_W-1:0]   imm;
   } entry_type;

   typedef struct packed {
      logic empty;
      logic full;
   } q_status_type;

   typedef struct packed {
      logic [REG_W-1:0] a_addr;
      logic [REG_W-1:0] b_addr;
   } rf_rd_type;

   typedef struct packed {
      logic              en;
      logic [REG_W-1:0]  addr;
      logic [DATA_W-1:0] data;
   } rf_wr_type;

endpackage

// File: rtl/core/msrae_front.sv
// Front end: accepts request transactions and classifies them for the queue.
`timescale 1ns / 1ps

module msrae_front (
   input  logic                        start,
   output logic                        busy,
   input  logic [3:0]                  req_mode,
   input  logic [msrae_pkg::REG_W-1:0] req_dest_reg,
   input  logic [msrae_pkg::REG_W-1:0] req_src_a,
   input  logic [msrae_pkg::REG_W-1:0] req_src_b,
   input  logic signed [31:0]          req_immediate,
   input  msrae_pkg::q_status_type     q_status,
   output logic                        push,
   output msrae_pkg::entry_type        push_data
);

   msrae_pkg::op_type op;

   always_comb begin
      if (req_mode <= 4'(msrae_pkg::OP_STOP)) begin
         op = msrae_pkg::op_type'(req_mode);
      end else begin
         op = msrae_pkg::OP_NOP;
      end
   end

   assign busy = q_status.full;
   assign push = start && !q_status.full;

   always_comb begin
      push_data.op     = op;
      push_data.writes = !(op == msrae_pkg::OP_DUMP || op == msrae_pkg::OP_NOP ||
                           op == msrae_pkg::OP_STOP);
      push_data.dest   = req_dest_reg;
      push_data.src_a  = req_src_a;
      push_data.src_b  = req_src_b;
      push_data.imm    = $unsigned(req_immediate);
   end

endmodule

// File: rtl/core/msrae_queue.sv
// Short FIFO decoupling the front end from the execution back end.
`timescale 1ns / 1ps

module msrae_queue (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    push,
   input  msrae_pkg::entry_type    push_data,
   input  logic                    pop,
   output msrae_pkg::entry_type    head,
   output msrae_pkg::q_status_type status
);

   localparam int PTR_W = $clog2(msrae_pkg::QUEUE_DEPTH);
   localparam int CNT_W = $clog2(msrae_pkg::QUEUE_DEPTH + 1);

   msrae_pkg::entry_type entries_ff [msrae_pkg::QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] p);
      if (p == PTR_W'(msrae_pkg::QUEUE_DEPTH - 1)) begin
         return '0;
      end
      return p + PTR_W'(1);
   endfunction

   always_comb begin
      wr_ptr_in = push ? ptr_next(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = pop ? ptr_next(rd_ptr_ff) : rd_ptr_ff;
      count_in  = count_ff + CNT_W'(push) - CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_data;
      end
   end

   assign head         = entries_ff[rd_ptr_ff];
   assign status.empty = (count_ff == '0);
   assign status.full  = (count_ff == CNT_W'(msrae_pkg::QUEUE_DEPTH));

endmodule

// File: rtl/core/msrae_regfile.sv
// Register file: two registered read ports with write bypass, one write port.
`timescale 1ns / 1ps

module msrae_regfile #(
   parameter int NUM_REGS = 32
) (
   input  logic                         clock,
   input  logic                         reset,
   input  msrae_pkg::rf_rd_type         rd_req,
   input  msrae_pkg::rf_wr_type         wr_req,
   output logic [msrae_pkg::DATA_W-1:0] rd_a_data,
   output logic [msrae_pkg::DATA_W-1:0] rd_b_data
);

   localparam int IDX_W = $clog2(NUM_REGS);
   localparam logic [msrae_pkg::REG_W:0] DEPTH = (msrae_pkg::REG_W + 1)'(NUM_REGS);

   logic [msrae_pkg::DATA_W-1:0] mem [NUM_REGS];
   logic [NUM_REGS-1:0]          valid_ff;
   logic [msrae_pkg::DATA_W-1:0] rd_a_ff, rd_b_ff;

   logic             wr_ok, a_rng, b_rng;
   logic [IDX_W-1:0] wi, ai, bi;

   assign a_rng = {1'b0, rd_req.a_addr} < DEPTH;
   assign b_rng = {1'b0, rd_req.b_addr} < DEPTH;
   assign wr_ok = wr_req.en && (wr_req.addr != '0) && ({1'b0, wr_req.addr} < DEPTH);
   assign wi    = wr_req.addr[IDX_W-1:0];
   assign ai    = rd_req.a_addr[IDX_W-1:0];
   assign bi    = rd_req.b_addr[IDX_W-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (wr_ok) begin
         valid_ff[wi] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_ok) begin
         mem[wi] <= wr_req.data;
      end
   end

   always_ff @(posedge clock) begin
      priority if (!a_rng) begin
         rd_a_ff <= '0;
      end else if (wr_ok && wr_req.addr == rd_req.a_addr) begin
         rd_a_ff <= wr_req.data;
      end else if (valid_ff[ai]) begin
         rd_a_ff <= mem[ai];
      end else begin
         rd_a_ff <= '0;
      end
      priority if (!b_rng) begin
         rd_b_ff <= '0;
      end else if (wr_ok && wr_req.addr == rd_req.b_addr) begin
         rd_b_ff <= wr_req.data;
      end else if (valid_ff[bi]) begin
         rd_b_ff <= mem[bi];
      end else begin
         rd_b_ff <= '0;
      end
   end

   assign rd_a_data = rd_a_ff;
   assign rd_b_data = rd_b_ff;

endmodule

// File: rtl/core/msrae_back.sv
// Back end: gating, ALU, dump sequencing, control registers and result register.
`timescale 1ns / 1ps
`include "mips_subset_register_alu_executor_unit_macros.svh"

module msrae_back #(
   parameter int NUM_REGS = 32
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         csr_valid,
   input  logic [0:0]                   csr_index,
   input  logic [msrae_pkg::PC_W-1:0]   csr_data,
   input  msrae_pkg::entry_type         head,
   input  msrae_pkg::q_status_type      q_status,
   output logic                         pop,
   output msrae_pkg::rf_rd_type         rd_req,
   output msrae_pkg::rf_wr_type         wr_req,
   input  logic [msrae_pkg::DATA_W-1:0] rd_a_data,
   input  logic [msrae_pkg::DATA_W-1:0] rd_b_data,
   output logic                         rsp_strobe,
   output logic [1:0]                   rsp_kind,
   output logic [msrae_pkg::REG_W-1:0]  rsp_reg_number,
   output logic signed [31:0]           rsp_reg_value,
   output logic [msrae_pkg::PC_W-1:0]   rsp_next_pc,
   output logic                         rsp_last
);

   localparam int IDX_W = $clog2(NUM_REGS);
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_REGS - 1);
   localparam logic [msrae_pkg::REG_W:0] DEPTH = (msrae_pkg::REG_W + 1)'(NUM_REGS);

   logic [msrae_pkg::PC_W-1:0] slice_limit_ff, program_length_ff;
   logic [msrae_pkg::PC_W-1:0] pc_ff, count_ff;
   logic                       stopped_ff;
   logic                       x_valid_ff;
   msrae_pkg::entry_type       x_entry_ff;
   logic                       dump_active_ff;
   logic [IDX_W-1:0]           dump_idx_ff;

   logic                          rsp_strobe_ff;
   msrae_pkg::kind_type           rsp_kind_ff;
   logic [msrae_pkg::REG_W-1:0]   rsp_reg_number_ff;
   logic [msrae_pkg::DATA_W-1:0]  rsp_reg_value_ff;
   logic [msrae_pkg::PC_W-1:0]    rsp_next_pc_ff;
   logic                          rsp_last_ff;

   logic                         refused, x_first, exec, is_dump, dump_last, x_done, dump_rd;
   logic                         dest_ok;
   logic [msrae_pkg::PC_W-1:0]   pc_inc;
   logic [msrae_pkg::REG_W-1:0]  dump_addr;
   logic [msrae_pkg::DATA_W-1:0] res;
   logic [4:0]                   shamt;

   assign refused   = stopped_ff || (pc_ff >= program_length_ff) ||
                      (count_ff >= slice_limit_ff);
   assign x_first   = x_valid_ff && !dump_active_ff;
   assign exec      = x_first && !refused;
   assign is_dump   = (x_entry_ff.op == msrae_pkg::OP_DUMP);
   assign dump_last = dump_active_ff && (dump_idx_ff == LAST_IDX);
   assign x_done    = x_valid_ff && (dump_active_ff ? dump_last : !(exec && is_dump));
   assign dump_rd   = x_valid_ff && !x_done;
   assign pop       = !q_status.empty && (!x_valid_ff || x_done);
   assign pc_inc    = pc_ff + msrae_pkg::PC_W'(1);
   assign dest_ok   = (x_entry_ff.dest != '0) && ({1'b0, x_entry_ff.dest} < DEPTH);
   assign shamt     = x_entry_ff.imm[4:0];

   // next dump register is read in the cycle before its result is captured
   assign dump_addr = dump_active_ff ?
                      msrae_pkg::REG_W'(dump_idx_ff) + msrae_pkg::REG_W'(1) :
                      msrae_pkg::REG_W'(1);

   assign rd_req.a_addr = dump_rd ? dump_addr : head.src_a;
   assign rd_req.b_addr = head.src_b;

   always_comb begin
      unique case (x_entry_ff.op)
         msrae_pkg::OP_LI:     res = x_entry_ff.imm;
         msrae_pkg::OP_ADD:    res = rd_a_data + rd_b_data;
         msrae_pkg::OP_SUB:    res = rd_a_data - rd_b_data;
         msrae_pkg::OP_ADDI:   res = rd_a_data + x_entry_ff.imm;
         msrae_pkg::OP_MUL:    res = msrae_pkg::DATA_W'(rd_a_data * rd_b_data);
         msrae_pkg::OP_AND:    res = rd_a_data & rd_b_data;
         msrae_pkg::OP_OR_REG: res = rd_a_data | rd_b_data;
         msrae_pkg::OP_OR_IMM: res = rd_a_data | x_entry_ff.imm;
         msrae_pkg::OP_XOR:    res = rd_a_data ^ rd_b_data;
         msrae_pkg::OP_SLL:    res = rd_a_data << shamt;
         msrae_pkg::OP_SRL:    res = rd_a_data >> shamt;
         default:              res = '0;
      endcase
   end

   assign wr_req.en   = exec && x_entry_ff.writes && (x_entry_ff.dest != '0);
   assign wr_req.addr = x_entry_ff.dest;
   assign wr_req.data = res;

   always_ff @(posedge clock) begin
      if (reset) begin
         slice_limit_ff    <= msrae_pkg::SLICE_LIMIT_RESET;
         program_length_ff <= msrae_pkg::PROGRAM_LENGTH_RESET;
         pc_ff             <= '0;
         count_ff          <= '0;
         stopped_ff        <= 1'b0;
         x_valid_ff        <= 1'b0;
         dump_active_ff    <= 1'b0;
         dump_idx_ff       <= '0;
         rsp_strobe_ff     <= 1'b0;
      end else begin
         if (csr_valid) begin
            unique case (msrae_pkg::csr_idx_type'(csr_index))
               msrae_pkg::CSR_SLICE_LIMIT:    slice_limit_ff    <= csr_data;
               msrae_pkg::CSR_PROGRAM_LENGTH: program_length_ff <= csr_data;
            endcase
         end
         x_valid_ff    <= pop || (x_valid_ff && !x_done);
         rsp_strobe_ff <= x_valid_ff;
         if (exec) begin
            pc_ff    <= pc_inc;
            count_ff <= count_ff + msrae_pkg::PC_W'(1);
            if (x_entry_ff.op == msrae_pkg::OP_STOP) begin
               stopped_ff <= 1'b1;
            end
            if (is_dump) begin
               dump_active_ff <= 1'b1;
               dump_idx_ff    <= IDX_W'(1);
            end
         end else if (dump_active_ff) begin
            if (dump_last) begin
               dump_active_ff <= 1'b0;
            end else begin
               dump_idx_ff <= dump_idx_ff + IDX_W'(1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         x_entry_ff <= head;
      end
      priority if (x_first && refused) begin
         rsp_kind_ff       <= msrae_pkg::KIND_REFUSED;
         rsp_reg_number_ff <= '0;
         rsp_reg_value_ff  <= '0;
         rsp_next_pc_ff    <= pc_ff;
         rsp_last_ff       <= 1'b1;
      end else if (x_first && is_dump) begin
         // register zero is always zero
         rsp_kind_ff       <= msrae_pkg::KIND_DUMP;
         rsp_reg_number_ff <= '0;
         rsp_reg_value_ff  <= '0;
         rsp_next_pc_ff    <= pc_inc;
         rsp_last_ff       <= 1'b0;
      end else if (x_first) begin
         rsp_kind_ff       <= msrae_pkg::KIND_EXEC;
         rsp_reg_number_ff <= x_entry_ff.writes ? x_entry_ff.dest : '0;
         rsp_reg_value_ff  <= (x_entry_ff.writes && dest_ok) ? res : '0;
         rsp_next_pc_ff    <= pc_inc;
         rsp_last_ff       <= 1'b1;
      end else begin
         rsp_kind_ff       <= msrae_pkg::KIND_DUMP;
         rsp_reg_number_ff <= msrae_pkg::REG_W'(dump_idx_ff);
         rsp_reg_value_ff  <= rd_a_data;
         rsp_next_pc_ff    <= pc_ff;
         rsp_last_ff       <= dump_last;
      end
   end

   assign rsp_strobe     = rsp_strobe_ff;
   assign rsp_kind       = rsp_kind_ff;
   assign rsp_reg_number = rsp_reg_number_ff;
   assign rsp_reg_value  = $signed(rsp_reg_value_ff);
   assign rsp_next_pc    = rsp_next_pc_ff;
   assign rsp_last       = rsp_last_ff;

   `MSRAE_ASSERT_IMPL(a_no_pop_in_dump, clock, reset, dump_rd, !pop,
      "queue popped while a dump is running")
   `MSRAE_ASSERT_IMPL(a_refused_clean, clock, reset,
      rsp_strobe_ff && rsp_kind_ff == msrae_pkg::KIND_REFUSED,
      rsp_reg_value_ff == '0 && rsp_reg_number_ff == '0 && rsp_last_ff,
      "refused transaction carries register data")
   `MSRAE_ASSERT_NEXT(a_dump_contiguous, clock, reset, rsp_strobe_ff && !rsp_last_ff,
      rsp_strobe_ff && rsp_kind_ff == msrae_pkg::KIND_DUMP,
      "gap or foreign result inside a dump")
   `MSRAE_ASSERT_NEXT(a_hold_only_in_dump, clock, reset, x_valid_ff && !x_done,
      x_valid_ff && dump_active_ff, "execute slot held outside a dump")

endmodule

// File: rtl/core/mips_subset_register_alu_executor_unit.sv
// Path: an accepted transaction passes through the queue, the execute slot and the result register.
// Throughput: one transaction per cycle through the execute slot, except while a dump holds
// that slot, reading one register per cycle, while the 4-entry queue fills.
// busy is high while the queue is full. Results cannot be stalled.
// Reset (synchronous): queue, counters, stop flag, register valid bits and control registers
// return to their defaults at once; there is no clearing pass.
`timescale 1ns / 1ps

module mips_subset_register_alu_executor_unit #(
   parameter int NUM_REGS = 32
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   output logic                        busy,
   input  logic [3:0]                  req_mode,
   input  logic [msrae_pkg::REG_W-1:0] req_dest_reg,
   input  logic [msrae_pkg::REG_W-1:0] req_src_a,
   input  logic [msrae_pkg::REG_W-1:0] req_src_b,
   input  logic signed [31:0]          req_immediate,
   output logic                        rsp_strobe,
   output logic [1:0]                  rsp_kind,
   output logic [msrae_pkg::REG_W-1:0] rsp_reg_number,
   output logic signed [31:0]          rsp_reg_value,
   output logic [msrae_pkg::PC_W-1:0]  rsp_next_pc,
   output logic                        rsp_last,
   input  logic                        csr_valid,
   output logic                        csr_ready,
   input  logic [0:0]                  csr_index,
   input  logic [msrae_pkg::PC_W-1:0]  csr_data
);

   msrae_pkg::q_status_type      q_status;
   msrae_pkg::entry_type         push_data, head;
   logic                         push, pop;
   msrae_pkg::rf_rd_type         rd_req;
   msrae_pkg::rf_wr_type         wr_req;
   logic [msrae_pkg::DATA_W-1:0] rd_a_data, rd_b_data;

   assign csr_ready = 1'b1;

   msrae_front u_front (
      .start         (start),
      .busy          (busy),
      .req_mode      (req_mode),
      .req_dest_reg  (req_dest_reg),
      .req_src_a     (req_src_a),
      .req_src_b     (req_src_b),
      .req_immediate (req_immediate),
      .q_status      (q_status),
      .push          (push),
      .push_data     (push_data)
   );

   msrae_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .pop       (pop),
      .head      (head),
      .status    (q_status)
   );

   msrae_regfile #(
      .NUM_REGS (NUM_REGS)
   ) u_regfile (
      .clock     (clock),
      .reset     (reset),
      .rd_req    (rd_req),
      .wr_req    (wr_req),
      .rd_a_data (rd_a_data),
      .rd_b_data (rd_b_data)
   );

   msrae_back #(
      .NUM_REGS (NUM_REGS)
   ) u_back (
      .clock          (clock),
      .reset          (reset),
      .csr_valid      (csr_valid),
      .csr_index      (csr_index),
      .csr_data       (csr_data),
      .head           (head),
      .q_status       (q_status),
      .pop            (pop),
      .rd_req         (rd_req),
      .wr_req         (wr_req),
      .rd_a_data      (rd_a_data),
      .rd_b_data      (rd_b_data),
      .rsp_strobe     (rsp_strobe),
      .rsp_kind       (rsp_kind),
      .rsp_reg_number (rsp_reg_number),
      .rsp_reg_value  (rsp_reg_value),
      .rsp_next_pc    (rsp_next_pc),
      .rsp_last       (rsp_last)
   );

endmodule
